FILE: hw/rtl/sd_spi_init_and_block_read_unit_defines.svh
// Assertion macros shared by the SD card SPI host RTL.
// No other dependencies; include after the clock and reset ports are declared.
`ifndef SD_SPI_INIT_AND_BLOCK_READ_UNIT_DEFINES_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_UNIT_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define SDSPI_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdspi: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define SDSPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdspi: next-cycle check failed");

`endif

FILE: hw/rtl/sdspi_pkg.sv
// Types and constants of the SD card SPI-mode host controller.
// No dependencies; imported by the sequencer and the top level.
`default_nettype none

package sdspi_pkg;

    // Request codes carried with every input request.
    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_READ = 2'd1,
        ACT_XFER = 2'd2
    } action_t;

    // Sequencer phases: each command has a send phase and a response wait phase.
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_DUMMY     = 5'd1,
        PH_CMD0_TX   = 5'd2,
        PH_CMD0_RX   = 5'd3,
        PH_CMD55_TX  = 5'd4,
        PH_CMD55_RX  = 5'd5,
        PH_ACMD41_TX = 5'd6,
        PH_ACMD41_RX = 5'd7,
        PH_CMD16_TX  = 5'd8,
        PH_CMD16_RX  = 5'd9,
        PH_CMD17_TX  = 5'd10,
        PH_CMD17_RX  = 5'd11,
        PH_TOKEN     = 5'd12,
        PH_DATA      = 5'd13
    } phase_t;

    typedef enum logic [2:0] {
        K_CMD0   = 3'd0,
        K_CMD55  = 3'd1,
        K_ACMD41 = 3'd2,
        K_CMD16  = 3'd3,
        K_CMD17  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select_active;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic       status;
    } result_t;

    localparam int         COMMAND_BYTES = 6;
    localparam int         WAIT_W        = 20;
    localparam int         DUMMY_W       = 8;
    localparam int         BLOCK_ADDR_W  = 27;
    localparam int         APB_ADDR_W    = 3;
    localparam int         APB_DATA_W    = 32;
    localparam int         S_TDATA_W     = 40;
    localparam int         M_TDATA_W     = 24;

    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [7:0] CMD0_CRC    = 8'h95;
    localparam logic [7:0] OP_CMD0     = 8'h40;
    localparam logic [7:0] OP_CMD55    = 8'h77;
    localparam logic [7:0] OP_ACMD41   = 8'h69;
    localparam logic [7:0] OP_CMD16    = 8'h50;
    localparam logic [7:0] OP_CMD17    = 8'h51;

    localparam logic [WAIT_W-1:0]  TIMEOUT_RESET = 20'd1000000;
    localparam logic [DUMMY_W-1:0] DUMMY_RESET   = 8'd200;

    // Register index, taken from paddr[2].
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_DUMMY   = 1'b1;

    function automatic logic [7:0] opcode(cmd_t k);
        logic [7:0] op;
        case (k)
            K_CMD0:   op = OP_CMD0;
            K_CMD55:  op = OP_CMD55;
            K_ACMD41: op = OP_ACMD41;
            K_CMD16:  op = OP_CMD16;
            K_CMD17:  op = OP_CMD17;
            default:  op = OP_CMD0;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdspi_seq.sv
// Command sequencer of the SD card SPI host: phase register, counters and
// the combinational decision of the next byte. Depends on sdspi_pkg.
`default_nettype none

module sdspi_seq
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     step,
    input  wire [1:0]               action,
    input  wire [BLOCK_ADDR_W-1:0]  block_address,
    input  wire [7:0]               rx_byte,
    input  wire [WAIT_W-1:0]        timeout_limit,
    input  wire [DUMMY_W-1:0]       dummy_bytes,
    output result_t                 res
);

    localparam int IDX_BITS = $clog2(BLOCK_BYTES + 1);
    localparam int IDX_W    = (IDX_BITS > DUMMY_W) ? IDX_BITS : DUMMY_W;
    localparam logic [IDX_W-1:0] BLOCK_LEN = IDX_W'(BLOCK_BYTES);
    localparam logic [IDX_W-1:0] CMD_LEN   = IDX_W'(COMMAND_BYTES);
    localparam logic [31:0]      BLOCK_ARG = 32'(BLOCK_BYTES);

    phase_t              phase_reg,        phase_next;
    logic [IDX_W-1:0]    byte_index_reg,   byte_index_next;
    logic [WAIT_W-1:0]   wait_count_reg,   wait_count_next;
    logic [WAIT_W-1:0]   retry_count_reg,  retry_count_next;
    logic [31:0]         byte_address_reg, byte_address_next;

    logic [WAIT_W-1:0]   limit;
    logic [WAIT_W-1:0]   wait_dec;
    logic [WAIT_W-1:0]   retry_dec;
    logic [IDX_W-1:0]    index_inc;
    cmd_t                kind;

    logic [7:0]          tx_byte_w;
    logic                tx_valid_w;
    logic [7:0]          data_byte_w;
    logic                data_valid_w;
    logic                done_w;
    logic                status_w;

    function automatic cmd_t cmd_of(phase_t ph);
        cmd_t k;
        case (ph)
            PH_CMD55_TX,  PH_CMD55_RX:  k = K_CMD55;
            PH_ACMD41_TX, PH_ACMD41_RX: k = K_ACMD41;
            PH_CMD16_TX,  PH_CMD16_RX:  k = K_CMD16;
            PH_CMD17_TX,  PH_CMD17_RX:  k = K_CMD17;
            default:                    k = K_CMD0;
        endcase
        return k;
    endfunction

    function automatic phase_t tx_phase(cmd_t k);
        phase_t ph;
        case (k)
            K_CMD55:  ph = PH_CMD55_TX;
            K_ACMD41: ph = PH_ACMD41_TX;
            K_CMD16:  ph = PH_CMD16_TX;
            K_CMD17:  ph = PH_CMD17_TX;
            default:  ph = PH_CMD0_TX;
        endcase
        return ph;
    endfunction

    function automatic phase_t rx_phase(cmd_t k);
        phase_t ph;
        case (k)
            K_CMD55:  ph = PH_CMD55_RX;
            K_ACMD41: ph = PH_ACMD41_RX;
            K_CMD16:  ph = PH_CMD16_RX;
            K_CMD17:  ph = PH_CMD17_RX;
            default:  ph = PH_CMD0_RX;
        endcase
        return ph;
    endfunction

    // Byte of a six-byte command frame: opcode, four argument bytes, then CRC 0x95 for CMD0 or the fill byte otherwise.
    function automatic logic [7:0] cmd_byte(cmd_t k, logic [2:0] pos, logic [31:0] addr);
        logic [31:0] arg;
        logic [7:0]  b;
        arg = '0;
        if (k == K_CMD16) arg = BLOCK_ARG;
        if (k == K_CMD17) arg = addr;
        case (pos)
            3'd0:    b = opcode(k);
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = (k == K_CMD0) ? CMD0_CRC : FILL_BYTE;
        endcase
        return b;
    endfunction

    // A zero limit still allows one try.
    assign limit     = (timeout_limit == '0) ? WAIT_W'(1) : timeout_limit;
    assign wait_dec  = wait_count_reg - WAIT_W'(1);
    assign retry_dec = retry_count_reg - WAIT_W'(1);
    assign index_inc = byte_index_reg + IDX_W'(1);
    assign kind      = cmd_of(phase_reg);

    // Output decision for the current request.
    always_comb begin
        tx_byte_w    = '0;
        tx_valid_w   = 1'b0;
        data_byte_w  = '0;
        data_valid_w = 1'b0;
        done_w       = 1'b0;
        status_w     = 1'b0;
        case (action)
            ACT_INIT: begin
                tx_valid_w = 1'b1;
                tx_byte_w  = (dummy_bytes != '0) ? FILL_BYTE : opcode(K_CMD0);
            end
            ACT_READ: begin
                tx_valid_w = 1'b1;
                tx_byte_w  = opcode(K_CMD17);
            end
            ACT_XFER: begin
                if (phase_reg != PH_IDLE) begin
                    tx_valid_w = 1'b1;
                    tx_byte_w  = FILL_BYTE;
                    case (phase_reg)
                        PH_DUMMY: begin
                            if (byte_index_reg >= IDX_W'(dummy_bytes)) begin
                                tx_byte_w = opcode(K_CMD0);
                            end
                        end
                        PH_CMD0_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_CMD16_TX,
                        PH_CMD17_TX: begin
                            if (byte_index_reg < CMD_LEN) begin
                                tx_byte_w = cmd_byte(kind, byte_index_reg[2:0],
                                                     byte_address_reg);
                            end
                        end
                        PH_CMD0_RX, PH_CMD55_RX, PH_ACMD41_RX, PH_CMD16_RX,
                        PH_CMD17_RX: begin
                            if (rx_byte == FILL_BYTE) begin
                                if (wait_dec == '0) begin
                                    done_w   = 1'b1;
                                    status_w = 1'b1;
                                end
                            end else begin
                                case (kind)
                                    K_CMD0:  tx_byte_w = opcode(K_CMD55);
                                    K_CMD55: tx_byte_w = opcode(K_ACMD41);
                                    K_ACMD41: begin
                                        if (rx_byte == 8'h00) begin
                                            tx_byte_w = opcode(K_CMD16);
                                        end else if (retry_dec == '0) begin
                                            done_w   = 1'b1;
                                            status_w = 1'b1;
                                        end else begin
                                            tx_byte_w = opcode(K_CMD55);
                                        end
                                    end
                                    K_CMD16: done_w = 1'b1;
                                    default: ;
                                endcase
                            end
                        end
                        PH_TOKEN: begin
                            if (rx_byte != DATA_TOKEN && wait_dec == '0) begin
                                done_w   = 1'b1;
                                status_w = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            data_byte_w  = rx_byte;
                            data_valid_w = 1'b1;
                            if (index_inc >= BLOCK_LEN) done_w = 1'b1;
                        end
                        default: begin
                            done_w   = 1'b1;
                            status_w = 1'b1;
                        end
                    endcase
                    if (done_w) begin
                        tx_valid_w = 1'b0;
                        tx_byte_w  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        wait_count_next   = wait_count_reg;
        retry_count_next  = retry_count_reg;
        byte_address_next = byte_address_reg;
        case (action)
            ACT_INIT: begin
                phase_next      = (dummy_bytes != '0) ? PH_DUMMY : PH_CMD0_TX;
                byte_index_next = IDX_W'(1);
            end
            ACT_READ: begin
                byte_address_next = 32'(32'(block_address) * BLOCK_ARG);
                phase_next        = PH_CMD17_TX;
                byte_index_next   = IDX_W'(1);
            end
            ACT_XFER: begin
                if (phase_reg != PH_IDLE) begin
                    case (phase_reg)
                        PH_DUMMY: begin
                            if (byte_index_reg < IDX_W'(dummy_bytes)) begin
                                byte_index_next = index_inc;
                            end else begin
                                phase_next      = PH_CMD0_TX;
                                byte_index_next = IDX_W'(1);
                            end
                        end
                        PH_CMD0_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_CMD16_TX,
                        PH_CMD17_TX: begin
                            if (byte_index_reg < CMD_LEN) begin
                                byte_index_next = index_inc;
                            end else begin
                                phase_next      = rx_phase(kind);
                                wait_count_next = limit;
                            end
                        end
                        PH_CMD0_RX, PH_CMD55_RX, PH_ACMD41_RX, PH_CMD16_RX,
                        PH_CMD17_RX: begin
                            if (rx_byte == FILL_BYTE) begin
                                wait_count_next = wait_dec;
                            end else begin
                                case (kind)
                                    K_CMD0: begin
                                        retry_count_next = limit;
                                        phase_next       = tx_phase(K_CMD55);
                                        byte_index_next  = IDX_W'(1);
                                    end
                                    K_CMD55: begin
                                        phase_next      = tx_phase(K_ACMD41);
                                        byte_index_next = IDX_W'(1);
                                    end
                                    K_ACMD41: begin
                                        retry_count_next = retry_dec;
                                        byte_index_next  = IDX_W'(1);
                                        phase_next       = (rx_byte == 8'h00) ?
                                                           tx_phase(K_CMD16) :
                                                           tx_phase(K_CMD55);
                                    end
                                    K_CMD17: begin
                                        phase_next      = PH_TOKEN;
                                        wait_count_next = limit;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        PH_TOKEN: begin
                            if (rx_byte == DATA_TOKEN) begin
                                phase_next      = PH_DATA;
                                byte_index_next = '0;
                            end else begin
                                wait_count_next = wait_dec;
                            end
                        end
                        PH_DATA: byte_index_next = index_inc;
                        default: ;
                    endcase
                    if (done_w) phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        res.tx_byte            = tx_byte_w;
        res.tx_valid           = tx_valid_w;
        res.chip_select_active = (phase_next != PH_IDLE);
        res.data_byte          = data_byte_w;
        res.data_valid         = data_valid_w;
        res.done_res           = done_w;
        res.status             = status_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= '0;
            wait_count_reg   <= '0;
            retry_count_reg  <= '0;
            byte_address_reg <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            wait_count_reg   <= wait_count_next;
            retry_count_reg  <= retry_count_next;
            byte_address_reg <= byte_address_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sd_spi_init_and_block_read_unit.sv
// SD card SPI-mode host: init sequence and 32-byte block read, one byte exchange per request.
// An accepted request is held in the input register, its result then in the output or skid register.
// Throughput: one request per cycle while the skid slot is empty; next byte decided combinationally.
// A skid register lets one more request in while a result waits on m_tready.
// Reset (aresetn low, synchronous) idles the sequencer, empties all stages and restores registers.
// Depends on sdspi_pkg, sdspi_seq and the assertion macro header.
`default_nettype none
`include "sd_spi_init_and_block_read_unit_defines.svh"

module sd_spi_init_and_block_read_unit
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // Configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [APB_ADDR_W-1:0]  paddr,
    input  wire [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request channel
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [S_TDATA_W-1:0]   s_tdata,  // block_address[26:0], rx_byte[34:27], zero pad
    input  wire [1:0]             s_tuser,  // action[1:0]
    // Result channel
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // tx_byte[7:0], chip_select_active[8],
                                            // data_byte[16:9], status[17], zero pad
    output logic [1:0]            m_tuser,  // tx_valid[0], data_valid[1]
    output logic                  m_tlast   // done_res
);

    logic [WAIT_W-1:0]       timeout_limit_reg, timeout_limit_next;
    logic [DUMMY_W-1:0]      dummy_bytes_reg,   dummy_bytes_next;
    logic                    cfg_write;

    logic                    in_valid_reg,  in_valid_next;
    logic [1:0]              in_action_reg;
    logic [BLOCK_ADDR_W-1:0] in_block_reg;
    logic [7:0]              in_rx_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    result_t                 out_reg, out_next;
    result_t                 skid_reg, skid_next;
    result_t                 seq_res;

    logic                    s_accept;
    logic                    step;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        timeout_limit_next = timeout_limit_reg;
        dummy_bytes_next   = dummy_bytes_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_TIMEOUT: timeout_limit_next = pwdata[WAIT_W-1:0];
                REG_DUMMY:   dummy_bytes_next   = pwdata[DUMMY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TIMEOUT: prdata = APB_DATA_W'(timeout_limit_reg);
            REG_DUMMY:   prdata = APB_DATA_W'(dummy_bytes_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= TIMEOUT_RESET;
            dummy_bytes_reg   <= DUMMY_RESET;
        end else begin
            timeout_limit_reg <= timeout_limit_next;
            dummy_bytes_reg   <= dummy_bytes_next;
        end
    end

    // The input register moves on whenever the skid slot is free, so a
    // result can always land in either the output or the skid register.
    assign step     = in_valid_reg && !skid_valid_reg;
    assign s_tready = !in_valid_reg || !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_block_reg  <= s_tdata[BLOCK_ADDR_W-1:0];
            in_rx_reg     <= s_tdata[BLOCK_ADDR_W +: 8];
        end
    end

    sdspi_seq #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .action        (in_action_reg),
        .block_address (in_block_reg),
        .rx_byte       (in_rx_reg),
        .timeout_limit (timeout_limit_reg),
        .dummy_bytes   (dummy_bytes_reg),
        .res           (seq_res)
    );

    // Output register with skid slot
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (step) begin
            if (!out_valid_reg || m_tready) begin
                out_next       = seq_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = seq_res;
                skid_valid_next = 1'b1;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.status, out_reg.data_byte,
                       out_reg.chip_select_active, out_reg.tx_byte};
    assign m_tuser  = {out_reg.data_valid, out_reg.tx_valid};
    assign m_tlast  = out_reg.done_res;

    // The skid slot only fills behind a stalled output register.
    `SDSPI_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A finished request releases chip select and starts no further exchange.
    `SDSPI_ASSERT_IMPLIES(a_done_releases, out_valid_reg && out_reg.done_res,
        !out_reg.tx_valid && !out_reg.chip_select_active)
    // A timeout status is only reported with the end of a request.
    `SDSPI_ASSERT_IMPLIES(a_status_with_done, out_valid_reg && out_reg.status,
        out_reg.done_res)
    // Block data only arrives while the card is selected or on the final byte.
    `SDSPI_ASSERT_IMPLIES(a_data_selected, out_valid_reg && out_reg.data_valid,
        out_reg.chip_select_active || out_reg.done_res)
    // An accepted request is held in the input register in the next cycle.
    `SDSPI_ASSERT_NEXT(a_accept_loads, s_accept, in_valid_reg)

endmodule

`default_nettype wire
